// File: sv/arpc_pkg.sv
`timescale 1ns / 1ps

package arpc_pkg;

	localparam int IP_W   = 32;
	localparam int MAC_W  = 48;
	localparam int AGE_W  = 8;
	localparam int SLOT_W = 4;
	localparam int CMD_W  = 2;
	localparam int ST_W   = 2;

	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_MISS = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL = 2'd2;

	localparam logic [AGE_W-1:0] AGE_MAX     = 8'hFF;
	localparam logic [AGE_W-1:0] TIMEOUT_RST = 8'd15;

	typedef struct packed {
		logic              vld;
		logic [CMD_W-1:0]  cmd;
		logic [IP_W-1:0]   ip;
		logic [MAC_W-1:0]  mac;
		logic              found;
		logic [MAC_W-1:0]  res_mac;
		logic [SLOT_W-1:0] slot;
	} tok_t;

endpackage

// File: sv/arp_cache_table_with_aging.sv
`timescale 1ns / 1ps

// ARP cache of ENTRIES slots, each a cell in a chain that holds one IP/MAC pair, a valid
// bit and an age. A command enters the first cell on acceptance and moves one cell per
// cycle down the chain; its result is registered at the output once it leaves the last cell,
// and the next command is taken only after the previous one has left the chain and the
// output is free. Lookup returns the highest-numbered matching slot, insert fills the
// lowest free slot, tick ages every valid slot and drops those past timeout_ticks.
// Write the timeout only while no command is in flight.

module arp_cache_table_with_aging import arpc_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,   // timeout_ticks
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // ip_addr[31:0], mac_addr[79:32]
	input  logic [1:0]  s_axis_tuser,  // command[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // found_mac[47:0], slot_index[51:48], zero[55:52]
	output logic [1:0]  m_axis_tuser   // status[1:0]
);

	logic [AGE_W-1:0]  timeout_q;
	logic              busy_q;
	logic              in_acc;
	tok_t              in_tok;
	tok_t              chain [ENTRIES];
	tok_t              last;
	logic [ST_W-1:0]   status_q;
	logic [MAC_W-1:0]  found_mac_q;
	logic [SLOT_W-1:0] slot_q;
	logic [ST_W-1:0]   status_n;
	logic [MAC_W-1:0]  found_mac_n;
	logic [SLOT_W-1:0] slot_n;

	assign s_axis_tready = !busy_q && (!m_axis_tvalid || m_axis_tready);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		in_tok     = '0;
		in_tok.vld = in_acc;
		in_tok.cmd = s_axis_tuser;
		in_tok.ip  = s_axis_tdata[IP_W-1:0];
		in_tok.mac = s_axis_tdata[IP_W+MAC_W-1:IP_W];
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		if (i == 0) begin : g_head
			arpc_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.slot_id (SLOT_W'(i)),
				.timeout (timeout_q),
				.tok_in  (in_tok),
				.tok_q   (chain[i])
			);
		end else begin : g_body
			arpc_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.slot_id (SLOT_W'(i)),
				.timeout (timeout_q),
				.tok_in  (chain[i-1]),
				.tok_q   (chain[i])
			);
		end
	end

	assign last = chain[ENTRIES-1];

	always_comb begin
		status_n    = ST_OK;
		found_mac_n = '0;
		slot_n      = '0;
		case (last.cmd)
			CMD_LOOKUP: begin
				if (last.found) begin
					found_mac_n = last.res_mac;
					slot_n      = last.slot;
				end else begin
					status_n = ST_MISS;
				end
			end
			CMD_INSERT: begin
				if (last.found) begin
					slot_n = last.slot;
				end else begin
					status_n = ST_FULL;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q     <= TIMEOUT_RST;
			busy_q        <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				timeout_q <= cfg_wr_data;
			end
			if (in_acc) begin
				busy_q <= 1'b1;
			end else if (last.vld) begin
				busy_q <= 1'b0;
			end
			if (last.vld) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (last.vld) begin
			status_q    <= status_n;
			found_mac_q <= found_mac_n;
			slot_q      <= slot_n;
		end
	end

	assign m_axis_tdata = {4'd0, slot_q, found_mac_q};
	assign m_axis_tuser = status_q;

endmodule

// File: sv/arpc_cell.sv
`timescale 1ns / 1ps

module arpc_cell import arpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SLOT_W-1:0] slot_id,
	input  logic [AGE_W-1:0]  timeout,
	input  tok_t              tok_in,
	output tok_t              tok_q
);

	logic              valid_q;
	logic [IP_W-1:0]   ip_q;
	logic [MAC_W-1:0]  mac_q;
	logic [AGE_W-1:0]  age_q;
	logic [AGE_W-1:0]  age_inc;
	logic              ins;
	logic              tick;
	tok_t              tok_n;

	assign age_inc = (age_q == AGE_MAX) ? AGE_MAX : age_q + AGE_W'(1);

	always_comb begin
		tok_n = tok_in;
		ins   = 1'b0;
		tick  = 1'b0;
		if (tok_in.vld) begin
			case (tok_in.cmd)
				CMD_LOOKUP: begin
					if (valid_q && ip_q == tok_in.ip) begin
						tok_n.found   = 1'b1;
						tok_n.res_mac = mac_q;
						tok_n.slot    = slot_id;
					end
				end
				CMD_INSERT: begin
					if (!tok_in.found && !valid_q) begin
						ins         = 1'b1;
						tok_n.found = 1'b1;
						tok_n.slot  = slot_id;
					end
				end
				CMD_TICK: begin
					tick = valid_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_n;
			if (ins) begin
				valid_q <= 1'b1;
			end else if (tick && age_inc > timeout) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ins) begin
			ip_q  <= tok_in.ip;
			mac_q <= tok_in.mac;
			age_q <= '0;
		end else if (tick) begin
			age_q <= age_inc;
		end
	end

endmodule
